@@ hw/rtl/mips_integer_execute_core_macros.svh @@
// Assertion helpers for the execute core checker.
`ifndef MIPS_INTEGER_EXECUTE_CORE_MACROS_SVH
`define MIPS_INTEGER_EXECUTE_CORE_MACROS_SVH
// Implication checked on every edge outside reset.
`define MIEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MIEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/miec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package miec_pkg;
    localparam logic [31:0] SpReset   = 32'h087F_FFFF;
    localparam logic [29:0] AddrMask  = 30'h3FFF_FFFF;
    localparam int          DivSteps  = 32;

    typedef enum logic [2:0] {
        LK_NONE = 3'd0, LK_LB = 3'd1, LK_LBU = 3'd2, LK_LH = 3'd3,
        LK_LHU = 3'd4, LK_LW = 3'd5
    } t_load_kind;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_FIX, ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the input beat
        logic exec;       // decode and execute with register reads
        logic mul_step;   // multiply product register
        logic div_start;
        logic div_step;
        logic div_fix;    // sign fixup and HI/LO write
        logic out_taken;  // result beat consumed
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_done;
    } t_sts;
endpackage
`default_nettype wire

@@ hw/rtl/miec_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module miec_ctrl import miec_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    output logic o_valid,
    input  wire  i_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_READ;
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: begin
                if (i_sts.is_mul) n_state = ST_MUL;
                else if (i_sts.is_div) n_state = ST_DIV;
                else n_state = ST_OUT;
            end
            ST_MUL: n_state = ST_FIX;
            ST_DIV: if (i_sts.div_done) n_state = ST_FIX;
            ST_FIX: n_state = ST_OUT;
            ST_OUT: if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_stall = (r_state != ST_IDLE) || !i_rst_n;
        o_valid = (r_state == ST_OUT);
        unique case (r_state)
            ST_IDLE: o_cmd.capture = i_valid;
            ST_READ: ;
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                o_cmd.div_start = i_sts.is_div;
            end
            ST_MUL:  o_cmd.mul_step = 1'b1;
            ST_DIV:  o_cmd.div_step = !i_sts.div_done;
            ST_FIX:  o_cmd.div_fix = 1'b1;
            ST_OUT:  o_cmd.out_taken = !i_stall;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/miec_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module miec_dp import miec_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  wire         i_op,
    input  wire  [31:0] i_instr_word,
    input  wire  [31:0] i_load_data,
    output logic [31:0] o_pc_next,
    output logic        o_reg_write_valid,
    output logic [4:0]  o_reg_write_index,
    output logic [31:0] o_reg_write_value,
    output logic        o_mem_read,
    output logic        o_mem_write,
    output logic [29:0] o_mem_address,
    output logic [2:0]  o_mem_width,
    output logic [31:0] o_mem_write_data,
    output logic        o_branch_taken,
    output logic        o_nullify_delay_slot,
    output logic        o_unhandled
);
    logic [31:0] r_gpr [32];
    logic [31:0] r_valid;   // entry written since reset
    logic [31:0] r_hi, r_lo, r_pc, r_dtgt, r_irq;
    logic        r_indly, r_dnull;
    logic [4:0]  r_ldest;
    t_load_kind  r_lkind;

    logic        r_op;
    logic [31:0] r_w, r_ld, r_a, r_b;
    logic [31:0] r_gpr_rs, r_gpr_rt;

    // multiply
    logic [63:0] r_prod;
    logic        r_msigned;
    // divide
    logic [31:0] r_dq, r_drem, r_dvs, r_dva, r_dvb;
    logic [5:0]  r_dcnt;
    logic        r_dsigned, r_dzero;
    logic        r_ismul;

    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    logic [31:0] simm;
    assign opc  = r_w[31:26];
    assign rs   = r_w[25:21];
    assign rt   = r_w[20:16];
    assign rd   = r_w[15:11];
    assign sa   = r_w[10:6];
    assign fn   = r_w[5:0];
    assign imm  = r_w[15:0];
    assign simm = {{16{imm[15]}}, imm};

    // read stage: registered register file reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_w  <= i_instr_word;
            r_ld <= i_load_data;
        end
        r_gpr_rs <= r_gpr[rs];
        r_gpr_rt <= r_gpr[rt];
    end
    always_comb begin
        r_a = r_valid[rs] ? r_gpr_rs : ((rs == 5'd29) ? SpReset : 32'd0);
        r_b = r_valid[rt] ? r_gpr_rt : ((rt == 5'd29) ? SpReset : 32'd0);
    end

    logic        x_we, x_taken, x_null, x_unh, x_mr, x_mw, x_mul, x_div, x_dsg;
    logic        x_hiw, x_low;
    logic [4:0]  x_wi;
    logic [31:0] x_wv, x_tgt, x_md, x_pc;
    logic [2:0]  x_mwid;
    logic [29:0] x_addr;
    t_load_kind  x_kind;
    logic [31:0] pc4, pc8, ldv;
    logic        neg, lez, irqw;

    assign pc4 = r_pc + 32'd4;
    assign pc8 = r_pc + 32'd8;
    assign neg = r_a[31];
    assign lez = (r_a == 32'd0) || r_a[31];

    always_comb begin
        x_we = 1'b0; x_wi = rd; x_wv = '0; x_taken = 1'b0; x_null = 1'b0;
        x_unh = 1'b0; x_mr = 1'b0; x_mw = 1'b0; x_mul = 1'b0; x_div = 1'b0;
        x_dsg = 1'b0; x_hiw = 1'b0; x_low = 1'b0;
        x_tgt = pc4 + {simm[29:0], 2'b00}; x_md = '0; x_mwid = '0;
        x_kind = LK_NONE; irqw = 1'b0;
        x_addr = (r_a[29:0] + simm[29:0]) & AddrMask;
        ldv = '0;
        if (r_op) begin
            x_wi = r_ldest;
            unique case (r_lkind)
                LK_LB:  begin x_we = 1'b1; ldv = {{24{r_ld[7]}}, r_ld[7:0]}; end
                LK_LBU: begin x_we = 1'b1; ldv = {24'd0, r_ld[7:0]}; end
                LK_LH:  begin x_we = 1'b1; ldv = {{16{r_ld[15]}}, r_ld[15:0]}; end
                LK_LHU: begin x_we = 1'b1; ldv = {16'd0, r_ld[15:0]}; end
                LK_LW:  begin x_we = 1'b1; ldv = r_ld; end
                default: ;
            endcase
            x_wv = ldv;
        end else begin
            unique case (opc)
                6'h00: begin
                    x_we = 1'b1;
                    unique case (fn)
                        6'h00: x_wv = r_b << sa;
                        6'h02: x_wv = r_b >> sa;
                        6'h03: x_wv = $signed(r_b) >>> sa;
                        6'h04: x_wv = r_b << r_a[4:0];
                        6'h06: x_wv = r_b >> r_a[4:0];
                        6'h07: x_wv = $signed(r_b) >>> r_a[4:0];
                        6'h08: begin x_we = 1'b0; x_taken = 1'b1; x_tgt = r_a; end
                        6'h09: begin x_wv = pc8; x_taken = 1'b1; x_tgt = r_a; end
                        6'h0A: begin x_we = (r_b == 32'd0); x_wv = r_a; end
                        6'h0B: begin x_we = (r_b != 32'd0); x_wv = r_a; end
                        6'h10: x_wv = r_hi;
                        6'h11: begin x_we = 1'b0; x_hiw = 1'b1; end
                        6'h12: x_wv = r_lo;
                        6'h13: begin x_we = 1'b0; x_low = 1'b1; end
                        6'h18, 6'h19: begin x_we = 1'b0; x_mul = 1'b1; end
                        6'h1A, 6'h1B: begin
                            x_we = 1'b0; x_div = 1'b1; x_dsg = (fn == 6'h1A);
                        end
                        6'h20, 6'h21: x_wv = r_a + r_b;
                        6'h22, 6'h23: x_wv = r_a - r_b;
                        6'h24: x_wv = r_a & r_b;
                        6'h25: x_wv = r_a | r_b;
                        6'h26: x_wv = r_a ^ r_b;
                        6'h27: x_wv = ~(r_a | r_b);
                        6'h2A: x_wv = {31'd0, $signed(r_a) < $signed(r_b)};
                        6'h2B: x_wv = {31'd0, r_a < r_b};
                        6'h0D, 6'h0F, 6'h30, 6'h31, 6'h32, 6'h33, 6'h34, 6'h36:
                            x_we = 1'b0;
                        default: begin x_we = 1'b0; x_unh = 1'b1; end
                    endcase
                end
                6'h01: begin
                    x_wi = 5'd31; x_wv = pc8;
                    unique case (rt)
                        5'h00: x_taken = neg;
                        5'h01: x_taken = !neg;
                        5'h02: begin x_taken = neg; x_null = !neg; end
                        5'h03: begin x_taken = !neg; x_null = neg; end
                        5'h10: begin x_we = 1'b1; x_taken = neg; end
                        5'h11: begin x_we = 1'b1; x_taken = !neg; end
                        5'h12: begin x_we = 1'b1; x_taken = neg; x_null = !neg; end
                        5'h13: begin x_we = 1'b1; x_taken = !neg; x_null = neg; end
                        5'h08, 5'h09, 5'h0A, 5'h0B, 5'h0C, 5'h0E: ;
                        default: x_unh = 1'b1;
                    endcase
                end
                6'h02, 6'h03: begin
                    x_we = (opc == 6'h03); x_wi = 5'd31; x_wv = pc8;
                    x_tgt = {pc4[31:28], r_w[25:0], 2'b00}; x_taken = 1'b1;
                end
                6'h04: x_taken = (r_a == r_b);
                6'h05: x_taken = (r_a != r_b);
                6'h06: x_taken = lez;
                6'h07: x_taken = !lez;
                6'h14: begin x_taken = (r_a == r_b); x_null = !x_taken; end
                6'h15: begin x_taken = (r_a != r_b); x_null = !x_taken; end
                6'h16: begin x_taken = lez; x_null = !x_taken; end
                6'h17: begin x_taken = !lez; x_null = !x_taken; end
                6'h08, 6'h09: begin x_we = 1'b1; x_wi = rt; x_wv = r_a + simm; end
                6'h0A: begin
                    x_we = 1'b1; x_wi = rt;
                    x_wv = {31'd0, $signed(r_a) < $signed(simm)};
                end
                6'h0B: begin x_we = 1'b1; x_wi = rt; x_wv = {31'd0, r_a < simm}; end
                6'h0C: begin x_we = 1'b1; x_wi = rt; x_wv = r_a & {16'd0, imm}; end
                6'h0D: begin x_we = 1'b1; x_wi = rt; x_wv = r_a | {16'd0, imm}; end
                6'h0E: begin x_we = 1'b1; x_wi = rt; x_wv = r_a ^ {16'd0, imm}; end
                6'h0F: begin x_we = 1'b1; x_wi = rt; x_wv = {imm, 16'd0}; end
                6'h1C: begin
                    x_wi = rt; x_wv = r_irq;
                    if (fn == 6'h00) ;
                    else if (fn == 6'h24) x_we = 1'b1;
                    else if (fn == 6'h26) irqw = 1'b1;
                    else x_unh = 1'b1;
                end
                6'h20: x_kind = LK_LB;
                6'h24: x_kind = LK_LBU;
                6'h21: x_kind = LK_LH;
                6'h25: x_kind = LK_LHU;
                6'h23: x_kind = LK_LW;
                6'h28: begin x_mw = 1'b1; x_mwid = 3'd1; x_md = {24'd0, r_b[7:0]}; end
                6'h29: begin x_mw = 1'b1; x_mwid = 3'd2; x_md = {16'd0, r_b[15:0]}; end
                6'h2B: begin x_mw = 1'b1; x_mwid = 3'd4; x_md = r_b; end
                6'h2F: ;
                default: x_unh = 1'b1;
            endcase
            if (x_kind != LK_NONE) begin
                x_mr = 1'b1;
                x_mwid = (x_kind <= LK_LBU) ? 3'd1 : ((x_kind <= LK_LHU) ? 3'd2 : 3'd4);
            end
        end
        if (x_wi == 5'd0) x_we = 1'b0;
        if (r_op) x_pc = r_pc;
        else if (x_taken) x_pc = pc4;
        else x_pc = r_indly ? r_dtgt : pc4;
    end

    assign o_sts.is_mul = !r_op && x_mul;
    assign o_sts.is_div = !r_op && x_div;
    assign o_sts.div_done = (r_dcnt == 6'(DivSteps));

    // divider: restoring, one quotient bit per cycle on magnitudes
    logic [32:0] dtrial;
    assign dtrial = {r_drem, r_dq[31]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && x_mul) begin
            r_msigned <= x_dsg || (fn == 6'h18);
            r_dva <= r_a; r_dvb <= r_b;
        end
        if (i_cmd.div_start) begin
            r_dsigned <= x_dsg;
            r_dzero   <= (r_b == 32'd0);
            r_dva <= r_a; r_dvb <= r_b;
            r_dq  <= (x_dsg && r_a[31]) ? -r_a : r_a;
            r_dvs <= (x_dsg && r_b[31]) ? -r_b : r_b;
            r_drem <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 6'd1;
            if (!dtrial[32]) begin
                r_drem <= dtrial[31:0];
                r_dq   <= {r_dq[30:0], 1'b1};
            end else begin
                r_drem <= {r_drem[30:0], r_dq[31]};
                r_dq   <= {r_dq[30:0], 1'b0};
            end
        end
        if (i_cmd.mul_step) begin
            if (r_msigned) r_prod <= 64'($signed(r_dva) * $signed(r_dvb));
            else           r_prod <= r_dva * r_dvb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_ismul <= x_mul;
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && x_we) r_gpr[x_wi] <= x_wv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hi <= '0; r_lo <= '0; r_pc <= '0; r_dtgt <= '0; r_irq <= '0;
            r_indly <= 1'b0; r_dnull <= 1'b0; r_ldest <= '0; r_lkind <= LK_NONE;
            o_pc_next <= '0; o_reg_write_valid <= 1'b0; o_reg_write_index <= '0;
            o_reg_write_value <= '0; o_mem_read <= 1'b0; o_mem_write <= 1'b0;
            o_mem_address <= '0; o_mem_width <= '0; o_mem_write_data <= '0;
            o_branch_taken <= 1'b0; o_nullify_delay_slot <= 1'b0; o_unhandled <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                if (x_we) r_valid[x_wi] <= 1'b1;
                r_lkind <= r_op ? LK_NONE : x_kind;
                if (!r_op && x_kind != LK_NONE) r_ldest <= rt;
                if (!r_op) begin
                    r_pc    <= x_pc;
                    r_dtgt  <= x_taken ? x_tgt : 32'd0;
                    r_indly <= x_taken;
                    r_dnull <= x_null;
                    if (x_hiw) r_hi <= r_a;
                    if (x_low) r_lo <= r_a;
                    if (irqw) r_irq <= r_b;
                end
                o_pc_next <= x_pc;
                o_reg_write_valid <= x_we;
                o_reg_write_index <= x_we ? x_wi : 5'd0;
                o_reg_write_value <= x_we ? x_wv : 32'd0;
                o_mem_read <= x_mr;
                o_mem_write <= x_mw;
                o_mem_address <= (x_mr || x_mw) ? x_addr : 30'd0;
                o_mem_width <= x_mwid;
                o_mem_write_data <= x_md;
                o_branch_taken <= x_taken;
                o_nullify_delay_slot <= x_null;
                o_unhandled <= x_unh;
            end
            if (i_cmd.div_fix) begin
                if (r_ismul) begin
                    r_hi <= r_prod[63:32];
                    r_lo <= r_prod[31:0];
                end else if (r_dzero) begin
                    r_lo <= '1;
                    r_hi <= r_dva;
                end else begin
                    r_lo <= (r_dsigned && (r_dva[31] ^ r_dvb[31])) ? -r_dq : r_dq;
                    r_hi <= (r_dsigned && r_dva[31]) ? -r_drem : r_drem;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/mips_integer_execute_core.sv @@
// MIPS integer execute core.
// Input channel: i_valid / o_stall carry one beat: i_op selects instruction
// execute (0) or load-data return (1), with i_instr_word or i_load_data.
// Output channel: o_valid / i_stall carry one result beat per input beat:
// next PC, register write, memory request, branch and nullify flags.
// One beat is in flight at a time; o_stall is high from acceptance until
// the result beat is taken.
// From acceptance to o_valid most instructions pass capture, register
// file read and execute; mult/multu add a registered 32x32 multiplier
// and HI/LO write, div/divu a restoring divider (one quotient bit per
// cycle) and sign fixup; it returns to idle before the next acceptance.
// A load needs a second beat (i_op = 1) with the memory word.
// Reset (synchronous, active low) restores the register file, with the
// stack pointer preset, and clears HI/LO, PC and delay-slot state;
// o_stall stays high while reset is held.
// While i_stall is high the result beat holds and no new beat is accepted.
`timescale 1ns / 1ps
`default_nettype none
module mips_integer_execute_core import miec_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_op,
    input  wire  [31:0] i_instr_word,
    input  wire  [31:0] i_load_data,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_pc_next,
    output logic        o_reg_write_valid,
    output logic [4:0]  o_reg_write_index,
    output logic [31:0] o_reg_write_value,
    output logic        o_mem_read,
    output logic        o_mem_write,
    output logic [29:0] o_mem_address,
    output logic [2:0]  o_mem_width,
    output logic [31:0] o_mem_write_data,
    output logic        o_branch_taken,
    output logic        o_nullify_delay_slot,
    output logic        o_unhandled
);
    t_cmd cmd;
    t_sts sts;

    // sequencer: one beat at a time
    miec_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cmd(cmd), .i_sts(sts)
    );

    // register file, ALU, multiplier, divider and result register
    miec_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts),
        .i_op(i_op), .i_instr_word(i_instr_word), .i_load_data(i_load_data),
        .o_pc_next(o_pc_next),
        .o_reg_write_valid(o_reg_write_valid),
        .o_reg_write_index(o_reg_write_index),
        .o_reg_write_value(o_reg_write_value),
        .o_mem_read(o_mem_read), .o_mem_write(o_mem_write),
        .o_mem_address(o_mem_address), .o_mem_width(o_mem_width),
        .o_mem_write_data(o_mem_write_data),
        .o_branch_taken(o_branch_taken),
        .o_nullify_delay_slot(o_nullify_delay_slot),
        .o_unhandled(o_unhandled)
    );
endmodule
`default_nettype wire

@@ hw/rtl/miec_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "mips_integer_execute_core_macros.svh"
module miec_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_valid,
    input wire o_stall,
    input wire o_valid,
    input wire i_stall,
    input wire o_reg_write_valid,
    input wire [4:0] o_reg_write_index,
    input wire o_mem_read,
    input wire o_mem_write
);
    `MIEC_ASSERT_IMP(a_no_r0_write, i_clk, i_rst_n, o_valid && o_reg_write_valid, o_reg_write_index != 5'd0)
    `MIEC_ASSERT_IMP(a_rd_wr_excl, i_clk, i_rst_n, o_valid, !(o_mem_read && o_mem_write))
    `MIEC_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, i_valid && !o_stall, o_stall && !o_valid)
    `MIEC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
endmodule
bind mips_integer_execute_core miec_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_reg_write_valid(o_reg_write_valid),
    .o_reg_write_index(o_reg_write_index), .o_mem_read(o_mem_read),
    .o_mem_write(o_mem_write)
);
`default_nettype wire
